// ===== rtl/pfdc_pkg.sv =====
package pfdc_pkg;

	// Number of instance slots; an index at or above this names no slot.
	localparam int unsigned SLOT_COUNT = 1024;

	localparam int NUM_PLANES = 6;
	localparam int NUM_REGS   = 7;
	localparam int IDX_W      = 10;
	localparam int POS_W      = 16;
	localparam int RANGE_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	// Aligns the Q12.4 plane offset with the Q.18 dot product.
	localparam int NORMAL_FRAC_SHIFT = 14;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_0 = 3'd0,
		REG_PLANE_1 = 3'd1,
		REG_PLANE_2 = 3'd2,
		REG_PLANE_3 = 3'd3,
		REG_PLANE_4 = 3'd4,
		REG_PLANE_5 = 3'd5,
		REG_CAMERA  = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		REASON_VISIBLE = 2'd0,
		REASON_FREE    = 2'd1,
		REASON_RANGE   = 2'd2,
		REASON_PLANE   = 2'd3
	} cull_reason_t;

	typedef struct packed {
		logic signed [POS_W-1:0] d;
		logic signed [POS_W-1:0] c;
		logic signed [POS_W-1:0] b;
		logic signed [POS_W-1:0] a;
	} plane_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
	} pos_t;

	// Decoded view of the configuration registers.
	typedef struct packed {
		plane_t [NUM_PLANES-1:0] planes;
		pos_t                    camera;
		logic [RANGE_W-1:0]      range;
		logic                    frustum_en;
	} cfg_t;

endpackage

// ===== rtl/pfdc_if.sv =====
// Input channel: one instance slot per beat.
interface pfdc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [pfdc_pkg::IDX_W-1:0]             slot_index;
	logic                                   slot_free;
	logic signed [pfdc_pkg::POS_W-1:0]      pos_x;
	logic signed [pfdc_pkg::POS_W-1:0]      pos_y;
	logic signed [pfdc_pkg::POS_W-1:0]      pos_z;

	modport source (output valid, slot_index, slot_free, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, slot_index, slot_free, pos_x, pos_y, pos_z, output ready);
endinterface

// Output channel: one cull verdict per beat.
interface pfdc_out_if;
	logic                       valid;
	logic                       ready;
	logic [pfdc_pkg::IDX_W-1:0] result_index;
	logic                       visible;
	logic [1:0]                 cull_reason;

	modport source (output valid, result_index, visible, cull_reason, input ready);
	modport sink (input valid, result_index, visible, cull_reason, output ready);
endinterface

// ===== rtl/pfdc_cfg_regs.sv =====
module pfdc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pfdc_pkg::cfg_t                      cfg
);

	logic [pfdc_pkg::CFG_DATA_W-1:0] regs_q [pfdc_pkg::NUM_REGS];

	// Register file; writes to an index beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < pfdc_pkg::NUM_REGS; r++) begin
				regs_q[r] <= '0;
			end
		end else if (cfg_we) begin
			for (int r = 0; r < pfdc_pkg::NUM_REGS; r++) begin
				if (cfg_index == pfdc_pkg::CFG_IDX_W'(r)) begin
					regs_q[r] <= cfg_data;
				end
			end
		end
	end

	// Field decode of the plane and camera words.
	always_comb begin
		for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++) begin
			cfg.planes[p] = regs_q[p];
		end
		cfg.camera.x   = regs_q[pfdc_pkg::REG_CAMERA][15:0];
		cfg.camera.y   = regs_q[pfdc_pkg::REG_CAMERA][31:16];
		cfg.camera.z   = regs_q[pfdc_pkg::REG_CAMERA][47:32];
		cfg.range      = regs_q[pfdc_pkg::REG_CAMERA][62:48];
		cfg.frustum_en = regs_q[pfdc_pkg::REG_CAMERA][63];
	end

endmodule

// ===== rtl/pfdc_range.sv =====
module pfdc_range (
	input  logic           clk,
	input  logic           en,
	input  pfdc_pkg::pos_t pos_s1,
	input  pfdc_pkg::cfg_t cfg,
	output logic           beyond
);

	logic signed [pfdc_pkg::POS_W:0]       dx, dy, dz;
	logic signed [2*pfdc_pkg::POS_W+1:0]   sqx, sqy, sqz;
	logic [2*pfdc_pkg::POS_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [2*pfdc_pkg::RANGE_W-1:0]        rsq_s2;
	logic [2*pfdc_pkg::POS_W+1:0]          dist_sq;

	// Offsets from the camera and their squares; each square fits 32 bits.
	always_comb begin
		dx  = (pfdc_pkg::POS_W+1)'(pos_s1.x) - (pfdc_pkg::POS_W+1)'(cfg.camera.x);
		dy  = (pfdc_pkg::POS_W+1)'(pos_s1.y) - (pfdc_pkg::POS_W+1)'(cfg.camera.y);
		dz  = (pfdc_pkg::POS_W+1)'(pos_s1.z) - (pfdc_pkg::POS_W+1)'(cfg.camera.z);
		sqx = dx * dx;
		sqy = dy * dy;
		sqz = dz * dz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= sqx[2*pfdc_pkg::POS_W-1:0];
			sqy_s2 <= sqy[2*pfdc_pkg::POS_W-1:0];
			sqz_s2 <= sqz[2*pfdc_pkg::POS_W-1:0];
			rsq_s2 <= cfg.range * cfg.range;
		end
	end

	// Sum of squares against the squared range; zero range disables the test.
	always_comb begin
		dist_sq = (2*pfdc_pkg::POS_W+2)'(sqx_s2) + (2*pfdc_pkg::POS_W+2)'(sqy_s2)
		        + (2*pfdc_pkg::POS_W+2)'(sqz_s2);
		beyond  = (cfg.range != '0) && (dist_sq > (2*pfdc_pkg::POS_W+2)'(rsq_s2));
	end

endmodule

// ===== rtl/pfdc_planes.sv =====
module pfdc_planes (
	input  logic           clk,
	input  logic           en,
	input  pfdc_pkg::pos_t pos_s1,
	input  pfdc_pkg::cfg_t cfg,
	output logic           outside
);

	localparam int PROD_W = 2 * pfdc_pkg::POS_W;
	localparam int SUM_W  = PROD_W + 3;

	logic signed [PROD_W-1:0] pa_s2 [pfdc_pkg::NUM_PLANES];
	logic signed [PROD_W-1:0] pb_s2 [pfdc_pkg::NUM_PLANES];
	logic signed [PROD_W-1:0] pc_s2 [pfdc_pkg::NUM_PLANES];
	logic signed [SUM_W-1:0]  plane_sum [pfdc_pkg::NUM_PLANES];
	logic [pfdc_pkg::NUM_PLANES-1:0] neg;

	// Normal times position, one product per component and plane.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++) begin
				pa_s2[p] <= cfg.planes[p].a * pos_s1.x;
				pb_s2[p] <= cfg.planes[p].b * pos_s1.y;
				pc_s2[p] <= cfg.planes[p].c * pos_s1.z;
			end
		end
	end

	// Signed plane distance in Q.18; a negative sum puts the point outside.
	always_comb begin
		for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++) begin
			plane_sum[p] = SUM_W'(pa_s2[p]) + SUM_W'(pb_s2[p]) + SUM_W'(pc_s2[p])
			             + (SUM_W'(cfg.planes[p].d) <<< pfdc_pkg::NORMAL_FRAC_SHIFT);
			neg[p]       = plane_sum[p][SUM_W-1];
		end
		outside = cfg.frustum_en && (neg != '0);
	end

endmodule

// ===== rtl/point_frustum_distance_cull_core.sv =====
// Point frustum and distance culling core.
// Each beat on the item channel carries one instance slot: its index, a
// free-slot flag and a Q12.4 position. Each item yields exactly one beat on
// the result channel with the echoed index, a visible flag and the cull
// reason (free slot, beyond range, outside a plane, in that priority).
// Planes, camera position, range and frustum enable sit in seven 64-bit
// registers loaded through the write port (cfg_we, cfg_index, cfg_data);
// load them only while no item is in flight.
// The input register loads at the accepting edge, then the register after the
// distance squares and plane products, then the result register that drives
// result valid. One item is accepted per cycle, limited only by the output
// side taking results.
// Reset clears the valid bits and configuration registers and empties the
// pipeline. When the receiver stalls, the result register holds its beat and
// the stages behind it keep filling until full, after which item ready drops.
module point_frustum_distance_cull_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	pfdc_in_if.sink                             item,
	pfdc_out_if.source                          result
);

	pfdc_pkg::cfg_t cfg;

	logic                       v_s1, v_s2, out_v_q;
	logic [pfdc_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_q;
	logic                       free_s1, free_s2;
	pfdc_pkg::pos_t             pos_s1;
	pfdc_pkg::cull_reason_t     reason_q, reason_d;
	logic                       adv_out, adv_2, adv_1;
	logic                       beyond, outside, beyond_count;

	pfdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfdc_range u_range (
		.clk    (clk),
		.en     (adv_2),
		.pos_s1 (pos_s1),
		.cfg    (cfg),
		.beyond (beyond)
	);

	pfdc_planes u_planes (
		.clk     (clk),
		.en      (adv_2),
		.pos_s1  (pos_s1),
		.cfg     (cfg),
		.outside (outside)
	);

	// Each stage moves when it is empty or its successor moves.
	assign adv_out    = !out_v_q || result.ready;
	assign adv_2      = !v_s2 || adv_out;
	assign adv_1      = !v_s1 || adv_2;
	assign item.ready = adv_1;

	assign beyond_count = {{(32 - pfdc_pkg::IDX_W){1'b0}}, item.slot_index}
	                      >= pfdc_pkg::SLOT_COUNT;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_1) begin
				v_s1 <= item.valid;
			end
			if (adv_2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Payload of the input and middle stages.
	always_ff @(posedge clk) begin
		if (adv_1) begin
			idx_s1   <= item.slot_index;
			free_s1  <= item.slot_free || beyond_count;
			pos_s1.x <= item.pos_x;
			pos_s1.y <= item.pos_y;
			pos_s1.z <= item.pos_z;
		end
		if (adv_2) begin
			idx_s2  <= idx_s1;
			free_s2 <= free_s1;
		end
	end

	// First failing test decides the reason.
	always_comb begin
		if (free_s2) begin
			reason_d = pfdc_pkg::REASON_FREE;
		end else if (beyond) begin
			reason_d = pfdc_pkg::REASON_RANGE;
		end else if (outside) begin
			reason_d = pfdc_pkg::REASON_PLANE;
		end else begin
			reason_d = pfdc_pkg::REASON_VISIBLE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			idx_q    <= idx_s2;
			reason_q <= reason_d;
		end
	end

	assign result.valid        = out_v_q;
	assign result.result_index = idx_q;
	assign result.cull_reason  = reason_q;
	assign result.visible      = (reason_q == pfdc_pkg::REASON_VISIBLE);

	// A free slot never leaves as visible.
	a_free_not_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && free_s2 && adv_out) |=> (reason_q == pfdc_pkg::REASON_FREE))
		else $error("free slot lost its reason");

	// An accepted item lands in the input stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> v_s1)
		else $error("accepted beat not captured");

	// A blocked middle stage keeps its item.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv_2) |=> (v_s2 && $stable(idx_s2) && $stable(free_s2)))
		else $error("middle stage dropped an item");

	// A stalled result beat cannot be overwritten by the stage behind it.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !result.ready) |=> (out_v_q && $stable(reason_q)))
		else $error("result overwritten while stalled");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

	// One expected cull verdict per accepted slot.
	typedef struct {
		logic [pfdc_pkg::IDX_W-1:0] index;
		logic                       visible;
		pfdc_pkg::cull_reason_t     reason;
	} verdict_t;

	// Kinds of register setup used by the random traffic.
	typedef enum int {
		SETUP_OPEN,
		SETUP_RANGE,
		SETUP_BOX,
		SETUP_BOTH,
		SETUP_RAW
	} setup_kind_t;

	localparam int SETTLE_LIMIT = 4000;
	localparam int TAIL_CYCLES  = 8;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pfdc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pfdc_pkg::CFG_DATA_W-1:0] cfg_data;

	pfdc_in_if  slot_ch ();
	pfdc_out_if verdict_ch ();

	point_frustum_distance_cull_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (slot_ch),
		.result    (verdict_ch)
	);

	// Copy of the culling registers as last written.
	logic [pfdc_pkg::CFG_DATA_W-1:0] cull_regs [pfdc_pkg::NUM_REGS];

	verdict_t verdicts_due [$];

	int fail_count    = 0;
	int slots_sent    = 0;
	int verdicts_seen = 0;
	int reg_writes    = 0;
	int reason_seen [4] = '{0, 0, 0, 0};

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_left     = 0;

	// Region that random positions are drawn around.
	int scene_x      = 0;
	int scene_y      = 0;
	int scene_z      = 0;
	int scene_spread = 32767;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Works out the verdict for one slot from the current register copy.
	function automatic verdict_t judge_slot(logic [pfdc_pkg::IDX_W-1:0] idx, logic free,
			shortint px, shortint py, shortint pz);
		verdict_t v;
		logic [pfdc_pkg::CFG_DATA_W-1:0] cam;
		longint dx, dy, dz, rng, dot;
		pfdc_pkg::plane_t pl;
		logic beyond;
		logic outside;
		cam = cull_regs[pfdc_pkg::REG_CAMERA];
		dx = longint'(px) - longint'($signed(cam[15:0]));
		dy = longint'(py) - longint'($signed(cam[31:16]));
		dz = longint'(pz) - longint'($signed(cam[47:32]));
		rng = longint'(cam[62:48]);
		beyond = (rng != 0) && (dx * dx + dy * dy + dz * dz > rng * rng);
		outside = 1'b0;
		if (cam[63]) begin
			for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++) begin
				pl = cull_regs[p];
				dot = longint'($signed(pl.a)) * longint'(px)
					+ longint'($signed(pl.b)) * longint'(py)
					+ longint'($signed(pl.c)) * longint'(pz)
					+ (longint'($signed(pl.d)) <<< pfdc_pkg::NORMAL_FRAC_SHIFT);
				if (dot < 0)
					outside = 1'b1;
			end
		end
		v.index = idx;
		if (free || idx >= pfdc_pkg::SLOT_COUNT)
			v.reason = pfdc_pkg::REASON_FREE;
		else if (beyond)
			v.reason = pfdc_pkg::REASON_RANGE;
		else if (outside)
			v.reason = pfdc_pkg::REASON_PLANE;
		else
			v.reason = pfdc_pkg::REASON_VISIBLE;
		v.visible = (v.reason == pfdc_pkg::REASON_VISIBLE);
		return v;
	endfunction

	// Every slot beat accepted by the block gets its verdict queued.
	always @(posedge clk) begin : predict_verdicts
		verdict_t due;
		if (arst_n && slot_ch.valid && slot_ch.ready) begin
			due = judge_slot(slot_ch.slot_index, slot_ch.slot_free,
				slot_ch.pos_x, slot_ch.pos_y, slot_ch.pos_z);
			verdicts_due.insert(verdicts_due.size(), due);
			slots_sent++;
		end
	end

	// Each verdict beat is compared with the oldest queued verdict.
	always @(posedge clk) begin : check_verdicts
		verdict_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("verdict beat with none expected: index %0d", verdict_ch.result_index);
				fail_count++;
			end else begin
				want = verdicts_due.pop_front();
				verdicts_seen++;
				reason_seen[want.reason]++;
				if (verdict_ch.result_index !== want.index) begin
					$error("result_index: expected %0d, got %0d", want.index,
						verdict_ch.result_index);
					fail_count++;
				end
				if (verdict_ch.visible !== want.visible) begin
					$error("visible: expected %0d, got %0d", want.visible, verdict_ch.visible);
					fail_count++;
				end
				if (verdict_ch.cull_reason !== want.reason) begin
					$error("cull_reason: expected %0d, got %0d", want.reason,
						verdict_ch.cull_reason);
					fail_count++;
				end
			end
		end
	end

	// Receiver: a long hold-off when asked, otherwise random stalls.
	initial begin
		verdict_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				verdict_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offers one slot beat after a random idle gap and waits until it is taken.
	task automatic send_slot(int idx, logic free, int x, int y, int z);
		int gap;
		gap = 0;
		while (gap < 16 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			slot_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		slot_ch.valid      <= 1'b1;
		slot_ch.slot_index <= (pfdc_pkg::IDX_W)'(idx);
		slot_ch.slot_free  <= free;
		slot_ch.pos_x      <= (pfdc_pkg::POS_W)'(x);
		slot_ch.pos_y      <= (pfdc_pkg::POS_W)'(y);
		slot_ch.pos_z      <= (pfdc_pkg::POS_W)'(z);
		do
			@(posedge clk);
		while (!slot_ch.ready);
	endtask

	// Stops offering beats and waits until every queued verdict has come back.
	task automatic settle_pipeline();
		int waited;
		waited = 0;
		slot_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (verdicts_due.size() != 0) begin
			$error("%0d verdicts never arrived", verdicts_due.size());
			fail_count++;
			verdicts_due.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the pipeline empty.
	task automatic write_reg(pfdc_pkg::reg_index_t r, logic [pfdc_pkg::CFG_DATA_W-1:0] w);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= w;
		cull_regs[r] = w;
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_plane(int p, int a, int b, int c, int d);
		write_reg(pfdc_pkg::reg_index_t'(p), {16'(d), 16'(c), 16'(b), 16'(a)});
	endtask

	task automatic set_camera(int x, int y, int z, int rng, logic frustum_on);
		write_reg(pfdc_pkg::REG_CAMERA, {frustum_on, 15'(rng), 16'(z), 16'(y), 16'(x)});
	endtask

	// Six roughly axis-aligned planes around a cube, normals slightly tilted.
	task automatic set_box(int cx, int cy, int cz, int h);
		set_plane(0, 16384, $urandom_range(1024) - 512, $urandom_range(1024) - 512, -(cx - h));
		set_plane(1, -16384, $urandom_range(1024) - 512, $urandom_range(1024) - 512, cx + h);
		set_plane(2, $urandom_range(1024) - 512, 16384, $urandom_range(1024) - 512, -(cy - h));
		set_plane(3, $urandom_range(1024) - 512, -16384, $urandom_range(1024) - 512, cy + h);
		set_plane(4, $urandom_range(1024) - 512, $urandom_range(1024) - 512, 16384, -(cz - h));
		set_plane(5, $urandom_range(1024) - 512, $urandom_range(1024) - 512, -16384, cz + h);
	endtask

	task automatic set_raw_planes();
		for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++)
			write_reg(pfdc_pkg::reg_index_t'(p), {$urandom, $urandom});
	endtask

	// Loads a random register setup and points the position source at it.
	task automatic random_setup(setup_kind_t kind);
		int cx, cy, cz, h, rng;
		logic [pfdc_pkg::CFG_DATA_W-1:0] cam;
		cx = int'($urandom_range(32000)) - 16000;
		cy = int'($urandom_range(32000)) - 16000;
		cz = int'($urandom_range(32000)) - 16000;
		h = $urandom_range(8000, 16);
		rng = $urandom_range(14000, 16);
		scene_x = cx;
		scene_y = cy;
		scene_z = cz;
		case (kind)
			SETUP_OPEN: begin
				set_raw_planes();
				set_camera(cx, cy, cz, 0, 1'b0);
				scene_spread = 32767;
			end
			SETUP_RANGE: begin
				set_raw_planes();
				set_camera(cx, cy, cz, rng, 1'b0);
				scene_spread = rng + rng / 3;
			end
			SETUP_BOX: begin
				set_box(cx, cy, cz, h);
				set_camera(cx, cy, cz, 0, 1'b1);
				scene_spread = h + h / 3;
			end
			SETUP_BOTH: begin
				set_box(cx, cy, cz, rng * 3 / 4);
				set_camera(cx, cy, cz, rng, 1'b1);
				scene_spread = rng + rng / 3;
			end
			default: begin
				set_raw_planes();
				cam = {$urandom, $urandom};
				write_reg(pfdc_pkg::REG_CAMERA, cam);
				scene_x = int'($signed(cam[15:0]));
				scene_y = int'($signed(cam[31:16]));
				scene_z = int'($signed(cam[47:32]));
				scene_spread = 32767;
			end
		endcase
	endtask

	// Mostly near the scene center, sometimes anywhere in the 16-bit range.
	function automatic int pick_coord(int center);
		int v;
		if ($urandom_range(3) == 0)
			return int'(shortint'($urandom));
		v = center + int'($urandom_range(2 * scene_spread)) - scene_spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	task automatic send_random_slot();
		int x, y, z;
		x = pick_coord(scene_x);
		y = pick_coord(scene_y);
		z = pick_coord(scene_z);
		send_slot(int'($urandom_range(pfdc_pkg::SLOT_COUNT - 1)), ($urandom_range(9) == 0),
			x, y, z);
	endtask

	// Registers at reset: every slot that is not free is visible.
	task automatic test_reset_defaults();
		send_slot(0, 1'b0, 0, 0, 0);
		send_slot(1023, 1'b0, 32767, -32768, 32767);
		send_slot(1023, 1'b1, -32768, 32767, -32768);
		send_slot('h2AA, 1'b0, -1, -1, -1);
		send_slot('h155, 1'b1, 0, 0, 0);
		settle_pipeline();
	endtask

	// Distance test at its boundary and at the extremes of camera and range.
	task automatic test_distance_cull();
		set_camera(0, 0, 0, 16, 1'b0);
		send_slot(1, 1'b0, 16, 0, 0);
		send_slot(2, 1'b0, 16, 1, 0);
		send_slot(3, 1'b0, -16, 0, 0);
		send_slot(4, 1'b0, 0, 0, 0);
		settle_pipeline();
		set_camera(-32768, -32768, -32768, 32767, 1'b0);
		send_slot(5, 1'b0, -32768, -32768, -32768);
		send_slot(6, 1'b0, 32767, 32767, 32767);
		settle_pipeline();
		set_camera(32767, 32767, 32767, 1, 1'b0);
		send_slot(7, 1'b0, 32767, 32767, 32767);
		send_slot(8, 1'b0, 32767, 32767, 32766);
		send_slot(9, 1'b0, 32766, 32766, 32767);
		send_slot(1023, 1'b1, -32768, -32768, -32768);
		settle_pipeline();
	endtask

	// Plane test: all-zero planes, a point on a plane, extreme coefficients,
	// and the priority of free slot over range over plane.
	task automatic test_plane_cull();
		for (int p = 0; p < pfdc_pkg::NUM_PLANES; p++)
			set_plane(p, 0, 0, 0, 0);
		set_camera(1000, -1000, 500, 0, 1'b1);
		send_slot(10, 1'b0, -32768, -32768, -32768);
		settle_pipeline();
		set_plane(0, 16384, 0, 0, 0);
		send_slot(11, 1'b0, 0, 123, -77);
		send_slot(12, 1'b0, -1, 0, 0);
		settle_pipeline();
		set_plane(5, -32768, -32768, -32768, -32768);
		send_slot(13, 1'b0, 0, -32768, -32768);
		send_slot(14, 1'b0, 32767, 32767, 32767);
		settle_pipeline();
		set_camera(0, 0, 0, 16, 1'b1);
		send_slot(15, 1'b0, -1000, 0, 0);
		send_slot(16, 1'b1, -1000, 0, 0);
		send_slot(17, 1'b0, 8, 8, 8);
		settle_pipeline();
	endtask

	// The receiver holds off long enough that the pipeline fills and the
	// slot channel stalls while beats keep being offered.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		random_setup(SETUP_BOTH);
		hold_left = 150;
		repeat (40) send_random_slot();
		settle_pipeline();
	endtask

	// Random slots under each register setup and each idling pattern.
	task automatic test_random_traffic();
		int send_pcts [4] = '{0, 52, 0, 6};
		int stall_pcts [4] = '{0, 0, 52, 6};
		for (int b = 0; b < 8; b++) begin
			random_setup(setup_kind_t'(b % 5));
			send_idle_pct = send_pcts[b % 4];
			stall_pct = stall_pcts[b % 4];
			repeat (225) send_random_slot();
			settle_pipeline();
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= pfdc_pkg::REG_PLANE_0;
		cfg_data           <= '0;
		slot_ch.valid      <= 1'b0;
		slot_ch.slot_index <= '0;
		slot_ch.slot_free  <= 1'b0;
		slot_ch.pos_x      <= '0;
		slot_ch.pos_y      <= '0;
		slot_ch.pos_z      <= '0;
		for (int i = 0; i < pfdc_pkg::NUM_REGS; i++)
			cull_regs[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_distance_cull();
		test_plane_cull();
		test_backpressure();
		test_random_traffic();
		settle_pipeline();

		$display("Sent %0d slots, checked %0d verdicts, %0d register writes.",
			slots_sent, verdicts_seen, reg_writes);
		$display("Verdicts: %0d visible, %0d free slot, %0d beyond range, %0d outside a plane.",
			reason_seen[pfdc_pkg::REASON_VISIBLE], reason_seen[pfdc_pkg::REASON_FREE],
			reason_seen[pfdc_pkg::REASON_RANGE], reason_seen[pfdc_pkg::REASON_PLANE]);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
